// ----- rtl/csvt_pkg.sv -----
`default_nettype none

package csvt_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } csvt_in_t;

    typedef struct packed {
        kind_t       item_kind;
        logic [7:0]  out_byte;
        logic [23:0] line_number;
        logic        hold_overflow;
        logic        run_last;
    } csvt_out_t;

    // parser mode, one-hot
    typedef enum logic [6:0] {
        MODE_LINE_START  = 7'b0000001,
        MODE_FIELD_START = 7'b0000010,
        MODE_UNQUOTED    = 7'b0000100,
        MODE_QUOTED      = 7'b0001000,
        MODE_QUOTE_SEEN  = 7'b0010000,
        MODE_AFTER_QUOTE = 7'b0100000,
        MODE_DISCARD     = 7'b1000000
    } mode_t;

    // result sequencer state, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FLUSH  = 5'b00010,
        ST_BYTE   = 5'b00100,
        ST_FIELD  = 5'b01000,
        ST_RECORD = 5'b10000
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_FLUSH  = 2'd0,
        SEL_BYTE   = 2'd1,
        SEL_FIELD  = 2'd2,
        SEL_RECORD = 2'd3
    } emit_sel_t;

    typedef struct packed {
        logic      accept;
        logic      load;
        logic      flush_step;
        emit_sel_t sel;
        logic      last;
    } csvt_cmd_t;

    typedef struct packed {
        logic dec_flush;
        logic dec_byte;
        logic dec_field;
        logic dec_record;
        logic flush_one;
        logic plan_byte;
        logic plan_field;
        logic plan_record;
    } csvt_status_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

endpackage

`default_nettype wire

// ----- rtl/csvt_dp.sv -----
`default_nettype none

module csvt_dp #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  csvt_pkg::csvt_in_t    in_data,
    input  csvt_pkg::csvt_cmd_t   cmd,
    output csvt_pkg::csvt_status_t status,
    output csvt_pkg::csvt_out_t   out_data
);

    localparam int PW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int SW = $clog2(2 * HOLD_DEPTH);

    csvt_pkg::mode_t mode_reg, mode_dec;
    logic [23:0]     line_count_reg, line_count_next;
    logic            line_started_reg, line_started_next;
    logic [PW-1:0]   head_reg, head_dec, head_inc;
    logic [CW-1:0]   count_reg, count_dec;
    logic [CW-1:0]   flush_cnt_reg, flush_dec;
    logic [7:0]      byte_reg, byte_dec;
    logic            ovf_reg, ovf_dec;
    logic            has_byte_reg, has_field_reg, has_record_reg;
    logic [7:0]      held_mem [HOLD_DEPTH];
    logic [7:0]      held_rd;
    csvt_pkg::csvt_out_t out_reg;

    logic [7:0]    c;
    logic          is_lf, is_quote, is_comma, is_hash, is_nul, lead, trim;
    logic          do_content, do_start, do_unq, do_aq;
    logic          dec_field, dec_record, dec_clear, dec_byte;
    logic          hold_we, full;
    logic [PW-1:0] hold_waddr;
    logic [SW-1:0] wr_sum;

    assign c        = in_data.in_byte;
    assign is_lf    = (c == csvt_pkg::CH_LF);
    assign is_quote = (c == csvt_pkg::CH_QUOTE);
    assign is_comma = (c == csvt_pkg::CH_COMMA);
    assign is_hash  = (c == csvt_pkg::CH_HASH);
    assign is_nul   = (c == csvt_pkg::CH_NUL);
    assign lead     = (c == csvt_pkg::CH_SP) || (c == csvt_pkg::CH_TAB)
                   || (c == csvt_pkg::CH_CR);
    assign trim     = lead || (c == csvt_pkg::CH_VT) || (c == csvt_pkg::CH_FF);

    assign held_rd  = held_mem[head_reg];
    assign head_inc = (head_reg == PW'(HOLD_DEPTH - 1)) ? '0 : head_reg + PW'(1);
    assign full     = (count_reg == CW'(HOLD_DEPTH));
    assign wr_sum   = SW'(head_reg) + SW'(count_reg);

    // parser mode decode
    always_comb
    begin
        mode_dec   = mode_reg;
        do_content = 1'b0;
        do_start   = 1'b0;
        do_unq     = 1'b0;
        do_aq      = 1'b0;
        dec_field  = 1'b0;
        dec_record = 1'b0;
        dec_clear  = 1'b0;
        if (in_data.stream_end)
        begin
            unique case (mode_reg)
                csvt_pkg::MODE_FIELD_START,
                csvt_pkg::MODE_AFTER_QUOTE:
                begin
                    dec_record = 1'b1;
                end
                csvt_pkg::MODE_UNQUOTED,
                csvt_pkg::MODE_QUOTED,
                csvt_pkg::MODE_QUOTE_SEEN:
                begin
                    dec_field  = 1'b1;
                    dec_record = 1'b1;
                end
                default:
                begin
                end
            endcase
            mode_dec  = csvt_pkg::MODE_LINE_START;
            dec_clear = 1'b1;
        end
        else if (!is_nul)
        begin
            unique case (mode_reg)
                csvt_pkg::MODE_LINE_START:
                begin
                    if (is_lf || lead)
                        mode_dec = csvt_pkg::MODE_LINE_START;
                    else if (is_hash)
                        mode_dec = csvt_pkg::MODE_DISCARD;
                    else
                        do_start = 1'b1;
                end
                csvt_pkg::MODE_FIELD_START:
                begin
                    if (is_lf)
                    begin
                        dec_record = 1'b1;
                        mode_dec   = csvt_pkg::MODE_LINE_START;
                    end
                    else if (!lead)
                        do_start = 1'b1;
                end
                csvt_pkg::MODE_UNQUOTED:
                begin
                    if (is_lf)
                    begin
                        dec_clear  = 1'b1;
                        dec_field  = 1'b1;
                        dec_record = 1'b1;
                        mode_dec   = csvt_pkg::MODE_LINE_START;
                    end
                    else
                        do_unq = 1'b1;
                end
                csvt_pkg::MODE_QUOTED:
                begin
                    if (is_lf)
                    begin
                        dec_clear  = 1'b1;
                        dec_field  = 1'b1;
                        dec_record = 1'b1;
                        mode_dec   = csvt_pkg::MODE_LINE_START;
                    end
                    else if (is_quote)
                        mode_dec = csvt_pkg::MODE_QUOTE_SEEN;
                    else
                        do_content = 1'b1;
                end
                csvt_pkg::MODE_QUOTE_SEEN:
                begin
                    if (is_quote)
                    begin
                        // doubled quote gives one quote byte
                        do_content = 1'b1;
                        mode_dec   = csvt_pkg::MODE_QUOTED;
                    end
                    else
                    begin
                        dec_clear = 1'b1;
                        dec_field = 1'b1;
                        do_aq     = 1'b1;
                    end
                end
                csvt_pkg::MODE_AFTER_QUOTE:
                begin
                    do_aq = 1'b1;
                end
                csvt_pkg::MODE_DISCARD:
                begin
                    if (is_lf)
                        mode_dec = csvt_pkg::MODE_LINE_START;
                end
                default:
                begin
                    mode_dec = csvt_pkg::MODE_LINE_START;
                end
            endcase

            if (do_start)
            begin
                if (is_quote)
                    mode_dec = csvt_pkg::MODE_QUOTED;
                else
                begin
                    mode_dec = csvt_pkg::MODE_UNQUOTED;
                    do_unq   = 1'b1;
                end
            end

            if (do_unq)
            begin
                if (is_comma)
                begin
                    dec_clear = 1'b1;
                    dec_field = 1'b1;
                    mode_dec  = csvt_pkg::MODE_FIELD_START;
                end
                else
                    do_content = 1'b1;
            end

            if (do_aq)
            begin
                if (is_lf)
                begin
                    dec_record = 1'b1;
                    mode_dec   = csvt_pkg::MODE_LINE_START;
                end
                else if (is_comma)
                    mode_dec = csvt_pkg::MODE_FIELD_START;
                else if (!lead)
                begin
                    dec_record = 1'b1;
                    mode_dec   = csvt_pkg::MODE_DISCARD;
                end
                else
                    mode_dec = csvt_pkg::MODE_AFTER_QUOTE;
            end
        end
    end

    // whitespace hold buffer, circular from head_reg
    always_comb
    begin
        count_dec  = count_reg;
        head_dec   = head_reg;
        flush_dec  = '0;
        byte_dec   = c;
        ovf_dec    = 1'b0;
        dec_byte   = 1'b0;
        hold_we    = 1'b0;
        hold_waddr = (wr_sum >= SW'(HOLD_DEPTH)) ? PW'(wr_sum - SW'(HOLD_DEPTH))
                                                 : PW'(wr_sum);
        if (do_content)
        begin
            if (trim)
            begin
                hold_we = 1'b1;
                if (full)
                begin
                    // oldest held byte forced out, its slot takes the new one
                    dec_byte   = 1'b1;
                    byte_dec   = held_rd;
                    ovf_dec    = 1'b1;
                    head_dec   = head_inc;
                    hold_waddr = head_reg;
                end
                else
                    count_dec = count_reg + CW'(1);
            end
            else
            begin
                flush_dec = count_reg;
                count_dec = '0;
                dec_byte  = 1'b1;
            end
        end
        else if (dec_clear)
            count_dec = '0;
    end

    // line counting
    always_comb
    begin
        line_count_next   = line_count_reg;
        line_started_next = line_started_reg;
        if (in_data.stream_end)
            line_started_next = 1'b0;
        else if (!is_nul)
        begin
            if (!line_started_reg && (line_count_reg != csvt_pkg::LINE_MAX))
                line_count_next = line_count_reg + 24'd1;
            line_started_next = !is_lf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= csvt_pkg::MODE_LINE_START;
            line_count_reg   <= '0;
            line_started_reg <= 1'b0;
            head_reg         <= '0;
            count_reg        <= '0;
            flush_cnt_reg    <= '0;
            has_byte_reg     <= 1'b0;
            has_field_reg    <= 1'b0;
            has_record_reg   <= 1'b0;
        end
        else if (cmd.accept)
        begin
            mode_reg         <= mode_dec;
            line_count_reg   <= line_count_next;
            line_started_reg <= line_started_next;
            head_reg         <= head_dec;
            count_reg        <= count_dec;
            flush_cnt_reg    <= flush_dec;
            has_byte_reg     <= dec_byte;
            has_field_reg    <= dec_field;
            has_record_reg   <= dec_record;
        end
        else if (cmd.flush_step)
        begin
            head_reg      <= head_inc;
            flush_cnt_reg <= flush_cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= byte_dec;
            ovf_reg  <= ovf_dec;
            if (hold_we)
                held_mem[hold_waddr] <= c;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_reg.line_number   <= line_count_reg;
            out_reg.run_last      <= cmd.last;
            unique case (cmd.sel)
                csvt_pkg::SEL_FLUSH:
                begin
                    out_reg.item_kind     <= csvt_pkg::KIND_BYTE;
                    out_reg.out_byte      <= held_rd;
                    out_reg.hold_overflow <= 1'b0;
                end
                csvt_pkg::SEL_BYTE:
                begin
                    out_reg.item_kind     <= csvt_pkg::KIND_BYTE;
                    out_reg.out_byte      <= byte_reg;
                    out_reg.hold_overflow <= ovf_reg;
                end
                csvt_pkg::SEL_FIELD:
                begin
                    out_reg.item_kind     <= csvt_pkg::KIND_FIELD;
                    out_reg.out_byte      <= '0;
                    out_reg.hold_overflow <= 1'b0;
                end
                default:
                begin
                    out_reg.item_kind     <= csvt_pkg::KIND_RECORD;
                    out_reg.out_byte      <= '0;
                    out_reg.hold_overflow <= 1'b0;
                end
            endcase
        end
    end

    assign out_data = out_reg;

    assign status.dec_flush   = (flush_dec != '0);
    assign status.dec_byte    = dec_byte;
    assign status.dec_field   = dec_field;
    assign status.dec_record  = dec_record;
    assign status.flush_one   = (flush_cnt_reg == CW'(1));
    assign status.plan_byte   = has_byte_reg;
    assign status.plan_field  = has_field_reg;
    assign status.plan_record = has_record_reg;

endmodule

`default_nettype wire

// ----- rtl/csvt_ctrl.sv -----
`default_nettype none

module csvt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  csvt_pkg::csvt_status_t status,
    output csvt_pkg::csvt_cmd_t    cmd
);

    csvt_pkg::ctrl_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  adv;

    // first pending step in emission order
    function automatic csvt_pkg::ctrl_state_t pick(input logic f, input logic b,
                                                   input logic fd, input logic r);
        csvt_pkg::ctrl_state_t s;
        if (f)
            s = csvt_pkg::ST_FLUSH;
        else if (b)
            s = csvt_pkg::ST_BYTE;
        else if (fd)
            s = csvt_pkg::ST_FIELD;
        else if (r)
            s = csvt_pkg::ST_RECORD;
        else
            s = csvt_pkg::ST_IDLE;
        return s;
    endfunction

    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.accept     = 1'b0;
        cmd.load       = 1'b0;
        cmd.flush_step = 1'b0;
        cmd.sel        = csvt_pkg::SEL_BYTE;
        unique case (state_reg)
            csvt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = pick(status.dec_flush, status.dec_byte,
                                      status.dec_field, status.dec_record);
                end
            end
            csvt_pkg::ST_FLUSH:
            begin
                cmd.sel = csvt_pkg::SEL_FLUSH;
                if (adv)
                begin
                    cmd.load       = 1'b1;
                    cmd.flush_step = 1'b1;
                    if (status.flush_one)
                        state_next = pick(1'b0, status.plan_byte,
                                          status.plan_field, status.plan_record);
                end
            end
            csvt_pkg::ST_BYTE:
            begin
                if (adv)
                begin
                    cmd.load   = 1'b1;
                    state_next = pick(1'b0, 1'b0, status.plan_field, status.plan_record);
                end
            end
            csvt_pkg::ST_FIELD:
            begin
                cmd.sel = csvt_pkg::SEL_FIELD;
                if (adv)
                begin
                    cmd.load   = 1'b1;
                    state_next = pick(1'b0, 1'b0, 1'b0, status.plan_record);
                end
            end
            csvt_pkg::ST_RECORD:
            begin
                cmd.sel = csvt_pkg::SEL_RECORD;
                if (adv)
                begin
                    cmd.load   = 1'b1;
                    state_next = csvt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = csvt_pkg::ST_IDLE;
            end
        endcase
        cmd.last = (state_next == csvt_pkg::ST_IDLE);
    end

    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csvt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == csvt_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/csv_field_tokenizer.sv -----
`default_nettype none

// streaming csv tokenizer: takes one text byte per transfer on the byte channel and
// returns field bytes, end-of-field and end-of-record marks on the tok channel, each
// tagged with the saturating line number; comment and blank lines give no record,
// trailing whitespace of a field is held back (up to HOLD_DEPTH bytes) and dropped
// when the field ends, and a nul byte is ignored. the result sequencer moves one result a
// cycle into the output register while the output is not stalled, and the next byte is
// taken once the sequence has drained
module csv_field_tokenizer #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // input byte channel
    input  logic                byte_valid,
    output logic                byte_ready,
    input  csvt_pkg::csvt_in_t  byte_data,
    // token result channel
    output logic                tok_valid,
    input  logic                tok_ready,
    output csvt_pkg::csvt_out_t tok_data
);

    // command and status between sequencer and datapath
    csvt_pkg::csvt_cmd_t    cmd;
    csvt_pkg::csvt_status_t status;

    // result sequencer: accepts a transfer when drained, then steps through
    // held-byte flush, content byte, end of field and end of record
    csvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_valid),
        .in_ready  (byte_ready),
        .out_valid (tok_valid),
        .out_ready (tok_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // parser mode, line counter, whitespace hold buffer and output register
    csvt_dp #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (byte_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (tok_data)
    );

endmodule

`default_nettype wire

// ----- rtl/csvt_checker.sv -----
`default_nettype none

module csvt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_ready,
    input logic                tok_valid,
    input logic                tok_ready,
    input csvt_pkg::csvt_out_t tok_data
);

    // stalled result keeps its payload
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_data))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> (tok_data.item_kind == csvt_pkg::KIND_BYTE)
                   || (tok_data.item_kind == csvt_pkg::KIND_FIELD)
                   || (tok_data.item_kind == csvt_pkg::KIND_RECORD))
        else $error("illegal result kind");

    // marks carry no byte and no overflow flag
    a_mark_clean: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_data.item_kind != csvt_pkg::KIND_BYTE)
            |-> (tok_data.out_byte == 8'h00) && !tok_data.hold_overflow)
        else $error("mark carries payload");

    // end of record is always the final result of its input
    a_record_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_data.item_kind == csvt_pkg::KIND_RECORD) |-> tok_data.run_last)
        else $error("record mark not last");

    // no new byte is taken while an earlier result sequence is not yet drained
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_data.run_last && !tok_ready |-> !byte_ready)
        else $error("input taken mid sequence");

endmodule

bind csv_field_tokenizer csvt_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_ready (byte_ready),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok_data   (tok_data)
);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import csvt_pkg::*;

    localparam int HOLD_DEPTH   = 16;
    localparam int PRED         = -1;               // row checked against the predictor
    localparam int DIR_ROWS     = 28;
    localparam int PHASE_ITEMS  = 30;               // countable text transfers per phase
    localparam int DRAIN_CYCLES = 2 * HOLD_DEPTH + 8;

    // one input transfer, with an optional hand-typed expectation
    typedef struct {
        csvt_in_t  item;
        int        n_typed;
        csvt_out_t typed [2];
    } stim_t;

    // directed table row: byte, end flag, repeat count, typed results
    typedef struct {
        logic [7:0]  chr;
        logic        fin;
        int          reps;
        int          n_typed;
        kind_t       kind0;
        logic [7:0]  chr0;
        kind_t       kind1;
        logic [23:0] line;
    } dir_row_t;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_ready;
    csvt_in_t  byte_data  = '0;
    logic      tok_valid;
    logic      tok_ready  = 1'b0;
    csvt_out_t tok_data;

    // tokenizer shadow state
    mode_t       prs_mode;
    logic [7:0]  ws_hold [HOLD_DEPTH];
    int          ws_count;
    logic [23:0] line_cnt;
    logic        in_line;

    csvt_out_t step_toks [$];       // tokens caused by the transfer being predicted
    csvt_out_t tok_expect_q [$];    // tokens still owed by the tokenizer
    stim_t     stim_q [$];          // transfers not yet offered
    stim_t     cur_stim;            // transfer now on the byte channel
    bit        byte_sent   = 1'b0;
    int        err_count   = 0;
    int        text_total  = 0;
    int        src_gap_pct = 0;
    int        sink_stall_pct = 0;
    dir_row_t  dir_tab [DIR_ROWS];

    always #1 clk = ~clk;

    csv_field_tokenizer #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_data   (tok_data)
    );

    // ---------------------------------------------------------------- predictor

    function automatic void emit_tok(kind_t kind, logic [7:0] chr, logic ovf);
        csvt_out_t t;
        t.item_kind     = kind;
        t.out_byte      = chr;
        t.line_number   = line_cnt;
        t.hold_overflow = ovf;
        t.run_last      = 1'b0;
        step_toks.push_back(t);
    endfunction

    // whitespace skipped ahead of a field
    function automatic bit is_lead_ws(logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_CR;
    endfunction

    // whitespace trimmed off the end of a field
    function automatic bit is_trim_ws(logic [7:0] c);
        return is_lead_ws(c) || c == CH_VT || c == CH_FF;
    endfunction

    function automatic void flush_hold();
        for (int i = 0; i < ws_count; i++)
            emit_tok(KIND_BYTE, ws_hold[i], 1'b0);
        ws_count = 0;
    endfunction

    // field body byte: whitespace waits in the hold until something follows it
    function automatic void field_content(logic [7:0] c);
        if (is_trim_ws(c))
        begin
            if (ws_count >= HOLD_DEPTH)
            begin
                // hold full, oldest byte is forced out and flagged
                emit_tok(KIND_BYTE, ws_hold[0], 1'b1);
                for (int i = 0; i < HOLD_DEPTH - 1; i++)
                    ws_hold[i] = ws_hold[i + 1];
                ws_count = HOLD_DEPTH - 1;
            end
            ws_hold[ws_count] = c;
            ws_count++;
        end
        else
        begin
            flush_hold();
            emit_tok(KIND_BYTE, c, 1'b0);
        end
    endfunction

    function automatic void unquoted_byte(logic [7:0] c);
        if (c == CH_COMMA)
        begin
            ws_count = 0;
            emit_tok(KIND_FIELD, 8'h00, 1'b0);
            prs_mode = MODE_FIELD_START;
        end
        else
            field_content(c);
    endfunction

    function automatic void open_field(logic [7:0] c);
        if (c == CH_QUOTE)
            prs_mode = MODE_QUOTED;
        else
        begin
            prs_mode = MODE_UNQUOTED;
            unquoted_byte(c);
        end
    endfunction

    function automatic void close_line();
        ws_count = 0;
        emit_tok(KIND_FIELD, 8'h00, 1'b0);
        emit_tok(KIND_RECORD, 8'h00, 1'b0);
        prs_mode = MODE_LINE_START;
    endfunction

    // past a close quote only a comma or leading whitespace keeps the record going
    function automatic void after_close_quote(logic [7:0] c);
        if (c == CH_LF)
        begin
            emit_tok(KIND_RECORD, 8'h00, 1'b0);
            prs_mode = MODE_LINE_START;
        end
        else if (c == CH_COMMA)
            prs_mode = MODE_FIELD_START;
        else if (!is_lead_ws(c))
        begin
            emit_tok(KIND_RECORD, 8'h00, 1'b0);
            prs_mode = MODE_DISCARD;
        end
    endfunction

    function automatic void take_text_byte(logic [7:0] c);
        case (prs_mode)
            MODE_FIELD_START:
            begin
                if (c == CH_LF)
                begin
                    emit_tok(KIND_RECORD, 8'h00, 1'b0);
                    prs_mode = MODE_LINE_START;
                end
                else if (!is_lead_ws(c))
                    open_field(c);
            end
            MODE_UNQUOTED:
            begin
                if (c == CH_LF)
                    close_line();
                else
                    unquoted_byte(c);
            end
            MODE_QUOTED:
            begin
                if (c == CH_LF)
                    close_line();
                else if (c == CH_QUOTE)
                    prs_mode = MODE_QUOTE_SEEN;
                else
                    field_content(c);
            end
            MODE_QUOTE_SEEN:
            begin
                if (c == CH_QUOTE)
                begin
                    // doubled quote stands for one quote
                    flush_hold();
                    emit_tok(KIND_BYTE, CH_QUOTE, 1'b0);
                    prs_mode = MODE_QUOTED;
                end
                else
                begin
                    ws_count = 0;
                    emit_tok(KIND_FIELD, 8'h00, 1'b0);
                    prs_mode = MODE_AFTER_QUOTE;
                    after_close_quote(c);
                end
            end
            MODE_AFTER_QUOTE:
                after_close_quote(c);
            MODE_DISCARD:
            begin
                if (c == CH_LF)
                    prs_mode = MODE_LINE_START;
            end
            default:
            begin
                prs_mode = MODE_LINE_START;
                if (c != CH_LF && !is_lead_ws(c))
                begin
                    if (c == CH_HASH)
                        prs_mode = MODE_DISCARD;
                    else
                        open_field(c);
                end
            end
        endcase
    endfunction

    // works out the tokens of one accepted transfer and queues them
    function automatic void predict_tokens(stim_t s);
        step_toks.delete();
        if (s.item.stream_end)
        begin
            case (prs_mode)
                MODE_FIELD_START, MODE_AFTER_QUOTE:
                    emit_tok(KIND_RECORD, 8'h00, 1'b0);
                MODE_UNQUOTED, MODE_QUOTED, MODE_QUOTE_SEEN:
                begin
                    emit_tok(KIND_FIELD, 8'h00, 1'b0);
                    emit_tok(KIND_RECORD, 8'h00, 1'b0);
                end
                default: ;
            endcase
            prs_mode = MODE_LINE_START;
            ws_count = 0;
            in_line  = 1'b0;
        end
        else if (s.item.in_byte != CH_NUL)
        begin
            // first non-nul byte of a line bumps the saturating line count
            if (!in_line)
            begin
                if (line_cnt != LINE_MAX)
                    line_cnt++;
                in_line = 1'b1;
            end
            take_text_byte(s.item.in_byte);
            if (s.item.in_byte == CH_LF)
                in_line = 1'b0;
        end
        if (step_toks.size() != 0)
            step_toks[step_toks.size() - 1].run_last = 1'b1;
        // directed rows with a typed expectation override the prediction
        if (s.n_typed != PRED)
        begin
            step_toks.delete();
            for (int i = 0; i < s.n_typed; i++)
                step_toks.push_back(s.typed[i]);
        end
        foreach (step_toks[i])
            tok_expect_q.push_back(step_toks[i]);
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_token(csvt_out_t got);
        csvt_out_t want;
        if (tok_expect_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected token kind %0d byte %02h line %0d",
                got.item_kind, got.out_byte, got.line_number));
            return;
        end
        want = tok_expect_q.pop_front();
        if (got.item_kind !== want.item_kind)
            report_mismatch($sformatf("item_kind %0d, want %0d", got.item_kind, want.item_kind));
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.line_number !== want.line_number)
            report_mismatch($sformatf("line_number %0d, want %0d",
                got.line_number, want.line_number));
        if (got.hold_overflow !== want.hold_overflow)
            report_mismatch($sformatf("hold_overflow %b, want %b",
                got.hold_overflow, want.hold_overflow));
        if (got.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b", got.run_last, want.run_last));
    endtask

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                byte_sent = 1'b1;
                predict_tokens(cur_stim);
            end
            if (tok_valid && tok_ready)
                check_token(tok_data);
        end
    end

    // ---------------------------------------------------------------- driving

    // byte channel: a new transfer is offered only once the last one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!byte_valid || byte_sent))
        begin
            byte_sent = 1'b0;
            if (stim_q.size() != 0 && $urandom_range(0, 99) >= src_gap_pct)
            begin
                cur_stim = stim_q.pop_front();
                byte_valid <= 1'b1;
                byte_data  <= cur_stim.item;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // token channel back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
            tok_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------- stimulus

    task automatic queue_text(logic [7:0] c, logic fin);
        stim_t s;
        s.item.in_byte    = c;
        s.item.stream_end = fin;
        s.n_typed         = PRED;
        s.typed[0]        = '0;
        s.typed[1]        = '0;
        stim_q.push_back(s);
        // nul bytes are dropped by the tokenizer and do not count
        if (fin || c != CH_NUL)
            text_total++;
    endtask

    function automatic logic [7:0] pick_ws(bit any_trim);
        logic [7:0] ws_set [5] = '{CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF};
        return ws_set[$urandom_range(0, any_trim ? 4 : 2)];
    endfunction

    // mostly printable field text, some whitespace and the odd nul
    function automatic logic [7:0] text_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            c = 8'($urandom_range(8'h21, 8'h7E));
            if (c == CH_COMMA || c == CH_QUOTE)
                c = 8'h7A;
        end
        else if (r < 95)
            c = pick_ws(1'b1);
        else
            c = CH_NUL;
        return c;
    endfunction

    // whitespace run, now and then long enough to overflow the hold
    task automatic queue_ws_run();
        int n;
        if ($urandom_range(0, 5) == 0)
            n = $urandom_range(HOLD_DEPTH - 2, HOLD_DEPTH + 4);
        else
            n = $urandom_range(0, 2);
        repeat (n)
            queue_text(pick_ws(1'b1), 1'b0);
        if ($urandom_range(0, 1) == 0)
            queue_text(text_char(), 1'b0);
    endtask

    // a well-formed record with random content, sometimes bent out of shape
    task automatic queue_record();
        int nf;
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0)
                queue_text(CH_COMMA, 1'b0);
            repeat ($urandom_range(0, 2))
                queue_text(pick_ws(1'b0), 1'b0);
            if ($urandom_range(0, 2) != 0)
            begin
                repeat ($urandom_range(0, 6))
                    queue_text(text_char(), 1'b0);
                queue_ws_run();
            end
            else
            begin
                queue_text(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 6))
                begin
                    case ($urandom_range(0, 9))
                        0: queue_text(CH_COMMA, 1'b0);
                        1:
                        begin
                            queue_text(CH_QUOTE, 1'b0);
                            queue_text(CH_QUOTE, 1'b0);
                        end
                        default: queue_text(text_char(), 1'b0);
                    endcase
                end
                if ($urandom_range(0, 3) == 0)
                    queue_ws_run();
                // unclosed quote runs into the line end
                if ($urandom_range(0, 9) == 0)
                    break;
                queue_text(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 1))
                    queue_text(pick_ws(1'b1), 1'b0);
                // junk after the close quote drops the rest of the line
                if ($urandom_range(0, 11) == 0)
                    queue_text(text_char(), 1'b0);
            end
        end
        if ($urandom_range(0, 4) == 0)
            queue_text(CH_COMMA, 1'b0);
        if ($urandom_range(0, 3) == 0)
            queue_text(CH_CR, 1'b0);
        if ($urandom_range(0, 19) == 0)
            queue_text(8'($urandom_range(0, 255)), 1'b1);
        else
            queue_text(CH_LF, 1'b0);
    endtask

    task automatic queue_line();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            // comment line
            repeat ($urandom_range(0, 2))
                queue_text(pick_ws(1'b0), 1'b0);
            queue_text(CH_HASH, 1'b0);
            repeat ($urandom_range(0, 5))
                queue_text(text_char(), 1'b0);
            queue_text(CH_LF, 1'b0);
        end
        else if (r < 14)
        begin
            // blank line
            repeat ($urandom_range(0, 3))
                queue_text(pick_ws(1'b0), 1'b0);
            queue_text(CH_LF, 1'b0);
        end
        else if (r < 26)
        begin
            // raw noise over the whole byte range
            repeat ($urandom_range(1, 10))
                queue_text(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
        else if (r < 30)
            queue_text(8'($urandom_range(0, 255)), 1'b1);
        else
            queue_record();
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        int          phase_start;
        stim_t       s;

        prs_mode = MODE_LINE_START;
        ws_count = 0;
        line_cnt = '0;
        in_line  = 1'b0;
        foreach (ws_hold[i])
            ws_hold[i] = 8'h00;

        // nul, field bytes, held space, commas, doubled quote, junk after a quote,
        // comment line, leading vt, hold overflow, stream end, unclosed quote,
        // empty trailing field, empty quoted field
        dir_tab = '{
            '{CH_NUL,   1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd0},
            '{8'h61,    1'b0, 1,  1,    KIND_BYTE,   8'h61,    KIND_BYTE,   24'd1},
            '{CH_SP,    1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd1},
            '{CH_COMMA, 1'b0, 1,  1,    KIND_FIELD,  8'h00,    KIND_BYTE,   24'd1},
            '{CH_QUOTE, 1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd1},
            '{CH_QUOTE, 1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd1},
            '{CH_QUOTE, 1'b0, 1,  1,    KIND_BYTE,   CH_QUOTE, KIND_BYTE,   24'd1},
            '{CH_QUOTE, 1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd1},
            '{8'h78,    1'b0, 1,  2,    KIND_FIELD,  8'h00,    KIND_RECORD, 24'd1},
            '{8'hFF,    1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd1},
            '{CH_LF,    1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd1},
            '{CH_TAB,   1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd2},
            '{CH_HASH,  1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd2},
            '{CH_LF,    1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd2},
            '{CH_VT,    1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd3},
            '{8'h80,    1'b0, 1,  PRED, KIND_BYTE,   8'h00,    KIND_BYTE,   24'd3},
            '{CH_FF,    1'b0, 17, PRED, KIND_BYTE,   8'h00,    KIND_BYTE,   24'd3},
            '{8'h7F,    1'b0, 1,  PRED, KIND_BYTE,   8'h00,    KIND_BYTE,   24'd3},
            '{8'hFF,    1'b1, 1,  2,    KIND_FIELD,  8'h00,    KIND_RECORD, 24'd3},
            '{8'h00,    1'b1, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd3},
            '{CH_QUOTE, 1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd4},
            '{8'h01,    1'b0, 1,  1,    KIND_BYTE,   8'h01,    KIND_BYTE,   24'd4},
            '{CH_LF,    1'b0, 1,  2,    KIND_FIELD,  8'h00,    KIND_RECORD, 24'd4},
            '{CH_COMMA, 1'b0, 1,  1,    KIND_FIELD,  8'h00,    KIND_BYTE,   24'd5},
            '{CH_LF,    1'b0, 1,  1,    KIND_RECORD, 8'h00,    KIND_BYTE,   24'd5},
            '{CH_QUOTE, 1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd6},
            '{CH_QUOTE, 1'b0, 1,  0,    KIND_BYTE,   8'h00,    KIND_BYTE,   24'd6},
            '{CH_LF,    1'b0, 1,  2,    KIND_FIELD,  8'h00,    KIND_RECORD, 24'd6}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++)
        begin
            // sender gaps, receiver stalls, then the other way round, then flat out
            src_gap_pct    = (ph == 0) ? 10 : (ph == 1) ? 67 : 0;
            sink_stall_pct = (ph == 0) ? 67 : (ph == 1) ? 10 : 0;

            if (ph == 0)
            begin
                foreach (dir_tab[r])
                begin
                    for (int k = 0; k < dir_tab[r].reps; k++)
                    begin
                        s.item.in_byte    = dir_tab[r].chr;
                        s.item.stream_end = dir_tab[r].fin;
                        s.n_typed         = dir_tab[r].n_typed;
                        s.typed[0] = '{dir_tab[r].kind0, dir_tab[r].chr0, dir_tab[r].line,
                                       1'b0, dir_tab[r].n_typed == 1};
                        s.typed[1] = '{dir_tab[r].kind1, 8'h00, dir_tab[r].line, 1'b0, 1'b1};
                        stim_q.push_back(s);
                    end
                end
            end

            phase_start = text_total;
            while (text_total - phase_start < PHASE_ITEMS)
                queue_line();

            while (stim_q.size() != 0 || byte_valid)
                @(posedge clk);
        end

        // let the last tokens drain, then give stray ones a chance to show up
        while (tok_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // hang guard
    initial
    begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
